// ===== sv/bta_pkg.sv =====
`default_nettype none
package bta_pkg;

   localparam int HEAP_BYTES = 4096;
   localparam int MIN_BLOCK  = 8;
   localparam int HEAP_EVEN  = (HEAP_BYTES + 1) / 2 * 2;
   localparam int MIN_EVEN   = (MIN_BLOCK + 1) / 2 * 2;
   localparam int TAG_WORDS  = HEAP_EVEN / 2;
   localparam int OFF_W      = 12;
   localparam int TAG_W      = 13;
   localparam int NEED_W     = 14;
   localparam int IDX_W      = 11;

   typedef logic [OFF_W-1:0]  off_type;
   typedef logic [TAG_W-1:0]  tag_type;
   typedef logic [NEED_W-1:0] need_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam off_type  FIRST_HDR    = off_type'(4);
   localparam off_type  END_TAG      = off_type'(HEAP_EVEN - 4);
   localparam need_type TAG_OVERHEAD = need_type'(8);
   localparam off_type  SPLIT_SLACK  = off_type'(16);
   localparam need_type MIN_NEED     = need_type'(MIN_EVEN);
   localparam tag_type  SENTINEL     = tag_type'(1);
   localparam tag_type  WHOLE_FREE   = tag_type'(HEAP_EVEN - 8);

   typedef enum logic [1:0] {
      KIND_FIRST = 2'd0,
      KIND_BEST  = 2'd1,
      KIND_FREE  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SRD,
      ST_SEV,
      ST_REL0,
      ST_REL1,
      ST_REL2,
      ST_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic    we;
      idx_type waddr;
      tag_type wdata;
      idx_type raddr;
   } ram_req_type;

   function automatic idx_type tag_idx(input off_type off);
      return off[OFF_W-1:1];
   endfunction

endpackage
`default_nettype wire

// ===== sv/bta_ifs.sv =====
`default_nettype none
interface bta_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [12:0]          req_size;
   logic [11:0]          block_addr;
   modport source (output valid, kind, req_size, block_addr, input ready);
   modport sink   (input valid, kind, req_size, block_addr, output ready);
endinterface

interface bta_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] result_addr;
   logic        ok;
   modport source (output valid, result_addr, ok, input ready);
   modport sink   (input valid, result_addr, ok, output ready);
endinterface
`default_nettype wire

// ===== sv/bta_ram.sv =====
`default_nettype none
module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== sv/bta_ctrl.sv =====
`default_nettype none
module bta_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      ready,
   input  wire logic [1:0]           kind,
   input  wire logic [12:0]          req_size,
   input  wire logic [11:0]          block_addr,
   input  wire logic                 slot_free,
   output logic                      done,
   output bta_pkg::off_type          result_addr,
   output logic                      result_ok,
   output bta_pkg::ram_req_type      ram_req,
   input  wire bta_pkg::tag_type     ram_rdata
);
   import bta_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   need_type  need_ff, need_in;
   off_type   p_ff, p_in, h_ff, h_in, s_ff, s_in;
   off_type   best_h_ff, best_h_in, best_s_ff, best_s_in;
   logic      found_ff, found_in;
   tag_type   prev_ff, prev_in;
   off_type   wa_ff [4];
   off_type   wa_in [4];
   tag_type   wd_ff [4];
   tag_type   wd_in [4];
   logic [1:0] wi_ff, wi_in, nw_ff, nw_in, icnt_ff, icnt_in;
   off_type   res_addr_ff, res_addr_in;
   logic      res_ok_ff, res_ok_in;

   need_type  sz;
   off_type   cur_s, tk_h, tk_s, tk_need, tk_rest, start_off;
   logic      cur_free, do_take, prev_free, next_free;
   tag_type   total;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         icnt_ff  <= '0;
         wi_ff    <= '0;
      end else begin
         state_ff <= state_in;
         icnt_ff  <= icnt_in;
         wi_ff    <= wi_in;
      end
      kind_ff     <= kind_in;
      need_ff     <= need_in;
      p_ff        <= p_in;
      h_ff        <= h_in;
      s_ff        <= s_in;
      best_h_ff   <= best_h_in;
      best_s_ff   <= best_s_in;
      found_ff    <= found_in;
      prev_ff     <= prev_in;
      wa_ff       <= wa_in;
      wd_ff       <= wd_in;
      nw_ff       <= nw_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff   <= res_ok_in;
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      need_in     = need_ff;
      p_in        = p_ff;
      h_in        = h_ff;
      s_in        = s_ff;
      best_h_in   = best_h_ff;
      best_s_in   = best_s_ff;
      found_in    = found_ff;
      prev_in     = prev_ff;
      wa_in       = wa_ff;
      wd_in       = wd_ff;
      nw_in       = nw_ff;
      wi_in       = wi_ff;
      icnt_in     = icnt_ff;
      res_addr_in = res_addr_ff;
      res_ok_in   = res_ok_ff;
      ready       = 1'b0;
      done        = 1'b0;
      ram_req     = '0;
      do_take     = 1'b0;
      tk_h        = h_ff;
      tk_s        = s_ff;
      total       = '0;
      start_off   = h_ff;

      sz = (need_type'(req_size) + need_type'(1)) & ~need_type'(1);
      if (sz < MIN_NEED) begin
         sz = MIN_NEED;
      end

      cur_s     = ram_rdata[OFF_W-1:0] & ~off_type'(1);
      cur_free  = !ram_rdata[0];
      prev_free = !prev_ff[0] && (prev_ff <= tag_type'(h_ff - FIRST_HDR));
      next_free = !ram_rdata[0];

      case (state_ff)
         ST_INIT: begin
            ram_req.we = 1'b1;
            case (icnt_ff)
               2'd0: begin
                  ram_req.waddr = tag_idx(off_type'(0));
                  ram_req.wdata = SENTINEL;
               end
               2'd1: begin
                  ram_req.waddr = tag_idx(FIRST_HDR);
                  ram_req.wdata = WHOLE_FREE;
               end
               2'd2: begin
                  ram_req.waddr = tag_idx(END_TAG - off_type'(4));
                  ram_req.wdata = WHOLE_FREE;
               end
               default: begin
                  ram_req.waddr = tag_idx(END_TAG);
                  ram_req.wdata = SENTINEL;
               end
            endcase
            icnt_in = icnt_ff + 2'd1;
            if (icnt_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               kind_in     = kind_type'(kind);
               need_in     = sz + TAG_OVERHEAD;
               p_in        = block_addr;
               h_in        = FIRST_HDR;
               found_in    = 1'b0;
               res_addr_in = '0;
               res_ok_in   = 1'b0;
               if (kind_type'(kind) == KIND_NONE) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SRD;
               end
            end
         end
         ST_SRD: begin
            ram_req.raddr = tag_idx(h_ff);
            if (h_ff < END_TAG) begin
               state_in = ST_SEV;
            end else if (kind_ff != KIND_FREE && found_ff) begin
               do_take = 1'b1;
               tk_h    = best_h_ff;
               tk_s    = best_s_ff;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SEV: begin
            s_in     = cur_s;
            h_in     = h_ff + cur_s;
            state_in = ST_SRD;
            tk_s     = cur_s;
            if (cur_s < off_type'(2)) begin
               h_in = END_TAG;
            end else if (kind_ff == KIND_FREE) begin
               if ((h_ff + FIRST_HDR) == p_ff) begin
                  state_in = cur_free ? ST_DONE : ST_REL0;
                  h_in     = h_ff;
               end else if ({1'b0, h_ff} + 13'd4 > {1'b0, p_ff}) begin
                  state_in = ST_DONE;
               end
            end else if (cur_free) begin
               if (kind_ff == KIND_FIRST) begin
                  if (need_type'(cur_s) >= need_ff) begin
                     do_take = 1'b1;
                  end
               end else if (need_type'(cur_s) == need_ff) begin
                  do_take = 1'b1;
               end else if (need_type'(cur_s) > need_ff &&
                            (!found_ff || cur_s < best_s_ff)) begin
                  found_in  = 1'b1;
                  best_h_in = h_ff;
                  best_s_in = cur_s;
               end
            end
         end
         ST_REL0: begin
            ram_req.raddr = tag_idx(h_ff - off_type'(4));
            state_in      = ST_REL1;
         end
         ST_REL1: begin
            prev_in       = ram_rdata;
            ram_req.raddr = tag_idx(h_ff + s_ff);
            state_in      = ST_REL2;
         end
         ST_REL2: begin
            total = tag_type'(s_ff);
            if (prev_free) begin
               start_off = h_ff - prev_ff[OFF_W-1:0];
               total     = total + prev_ff;
            end
            if (next_free) begin
               total = total + ram_rdata;
            end
            wa_in[0]  = start_off;
            wd_in[0]  = total;
            wa_in[1]  = start_off + total[OFF_W-1:0] - off_type'(4);
            wd_in[1]  = total;
            nw_in     = 2'd1;
            wi_in     = '0;
            res_ok_in = 1'b1;
            state_in  = ST_WR;
         end
         ST_WR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = tag_idx(wa_ff[wi_ff]);
            ram_req.wdata = wd_ff[wi_ff];
            wi_in         = wi_ff + 2'd1;
            if (wi_ff == nw_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      tk_need = need_ff[OFF_W-1:0];
      tk_rest = tk_s - tk_need;
      if (do_take) begin
         wi_in       = '0;
         res_ok_in   = 1'b1;
         res_addr_in = tk_h + off_type'(4);
         state_in    = ST_WR;
         if (tk_rest <= SPLIT_SLACK) begin
            wa_in[0] = tk_h;
            wd_in[0] = tag_type'(tk_s) | SENTINEL;
            wa_in[1] = tk_h + tk_s - off_type'(4);
            wd_in[1] = tag_type'(tk_s) | SENTINEL;
            nw_in    = 2'd1;
         end else begin
            wa_in[0] = tk_h;
            wd_in[0] = tag_type'(tk_need) | SENTINEL;
            wa_in[1] = tk_h + tk_need - off_type'(4);
            wd_in[1] = tag_type'(tk_need) | SENTINEL;
            wa_in[2] = tk_h + tk_need;
            wd_in[2] = tag_type'(tk_rest);
            wa_in[3] = tk_h + tk_s - off_type'(4);
            wd_in[3] = tag_type'(tk_rest);
            nw_in    = 2'd3;
         end
      end
   end

   assign result_addr = res_addr_ff;
   assign result_ok   = res_ok_ff;

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> (state_ff == ST_INIT || state_ff == ST_WR))
      else $error("tag store written outside init or write-back");
   a_free_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (done && kind_ff == KIND_FREE) |-> result_addr == '0)
      else $error("free returned a nonzero address");
   a_ok_addr: assert property (@(posedge clock) disable iff (reset)
      (done && kind_ff != KIND_FREE) |-> (result_ok == (result_addr != '0)))
      else $error("allocate status and address disagree");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && ready) |=> !ready)
      else $error("accepted a request without leaving idle");
endmodule
`default_nettype wire

// ===== sv/boundary_tag_heap_allocator_unit.sv =====
`default_nettype none
// Boundary-tag heap allocator over a 4096-byte heap whose tags live in a
// 2048-entry single-port-read tag RAM. After reset the unit writes the two
// sentinels and the single free block before it raises ready.
// Each request walks the block chain in address order through the one RAM
// read port, with a read state and an evaluate state per block visited,
// then writes back up to four tags one per cycle. Exactly one response beat
// follows each request beat, and a new request is taken while the previous
// response still waits in the output register.
module boundary_tag_heap_allocator_unit (
   input wire logic clock,
   input wire logic reset,
   bta_req_if.sink  req_ch,
   bta_rsp_if.source rsp_ch
);
   import bta_pkg::*;

   ram_req_type ram_req;
   tag_type     ram_rdata;
   logic        done, slot_free, res_ok;
   off_type     res_addr;
   logic        rsp_valid_ff, rsp_valid_in;
   off_type     rsp_addr_ff, rsp_addr_in;
   logic        rsp_ok_ff, rsp_ok_in;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   bta_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (req_ch.valid),
      .ready       (req_ch.ready),
      .kind        (req_ch.kind),
      .req_size    (req_ch.req_size),
      .block_addr  (req_ch.block_addr),
      .slot_free   (slot_free),
      .done        (done),
      .result_addr (res_addr),
      .result_ok   (res_ok),
      .ram_req     (ram_req),
      .ram_rdata   (ram_rdata)
   );

   bta_ram #(.WIDTH(TAG_W), .DEPTH(TAG_WORDS)) u_tags (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr;
         rsp_ok_in    = res_ok;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_addr_ff <= rsp_addr_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;
   assign rsp_ch.ok          = rsp_ok_ff;
endmodule
`default_nettype wire
